>>> hw/rtl/strmq_pkg.sv
// Shared types and constants for the sparse-table range-minimum engine.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package strmq_pkg;

	localparam int DEPTH_DEF  = 1024;
	localparam int LEVELS_DEF = 11;

	localparam int VALUE_W = 32;
	localparam int INDEX_W = 10;
	localparam int LEN_W   = INDEX_W + 1;
	localparam int LOG_W   = 4;
	localparam int OP_W    = 2;
	localparam int S_DATA_W = 56;
	localparam int M_DATA_W = 32;
	localparam int M_USER_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 2'd0,
		OP_QUERY  = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_FILL,
		ST_QREAD_A,
		ST_QREAD_B,
		ST_QRESULT
	} state_t;

	typedef struct packed {
		logic load_in;
		logic clear_count;
		logic append_start;
		logic fill_step;
		logic query_decode;
		logic read_a;
		logic read_b;
		logic result_load;
	} cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            full;
		logic            more;
		logic            flagged;
		logic            out_free;
	} status_t;

endpackage

`default_nettype wire

>>> hw/rtl/strmq_ctrl.sv
// Sequencer for the range-minimum engine: decodes items and steps the datapath.
// Depends on strmq_pkg for the state, command and status types.
`default_nettype none

module strmq_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  strmq_pkg::status_t   status,
	output strmq_pkg::cmd_t      cmd
);

	strmq_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= strmq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			strmq_pkg::ST_IDLE: begin
				if (in_valid) state_d = strmq_pkg::ST_DECODE;
			end
			strmq_pkg::ST_DECODE: begin
				case (status.op)
					strmq_pkg::OP_APPEND: begin
						if (!status.full && status.more) state_d = strmq_pkg::ST_FILL;
						else state_d = strmq_pkg::ST_IDLE;
					end
					strmq_pkg::OP_QUERY: begin
						if (status.flagged) state_d = strmq_pkg::ST_QRESULT;
						else state_d = strmq_pkg::ST_QREAD_A;
					end
					default: state_d = strmq_pkg::ST_IDLE;
				endcase
			end
			strmq_pkg::ST_FILL: begin
				if (!status.more) state_d = strmq_pkg::ST_IDLE;
			end
			strmq_pkg::ST_QREAD_A: state_d = strmq_pkg::ST_QREAD_B;
			strmq_pkg::ST_QREAD_B: state_d = strmq_pkg::ST_QRESULT;
			strmq_pkg::ST_QRESULT: begin
				if (status.out_free) state_d = strmq_pkg::ST_IDLE;
			end
			default: state_d = strmq_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			strmq_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			strmq_pkg::ST_DECODE: begin
				case (status.op)
					strmq_pkg::OP_APPEND: cmd.append_start = !status.full;
					strmq_pkg::OP_QUERY:  cmd.query_decode = 1'b1;
					strmq_pkg::OP_CLEAR:  cmd.clear_count  = 1'b1;
					default: ;
				endcase
			end
			strmq_pkg::ST_FILL:    cmd.fill_step   = 1'b1;
			strmq_pkg::ST_QREAD_A: cmd.read_a      = 1'b1;
			strmq_pkg::ST_QREAD_B: cmd.read_b      = 1'b1;
			strmq_pkg::ST_QRESULT: cmd.result_load = status.out_free;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

>>> hw/rtl/strmq_dp.sv
// Datapath of the range-minimum engine: input and output registers, loaded count,
// window-minimum memory and the min/flag logic. Depends on strmq_pkg.
`default_nettype none

module strmq_dp #(
	parameter int DEPTH  = strmq_pkg::DEPTH_DEF,
	parameter int LEVELS = strmq_pkg::LEVELS_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  strmq_pkg::cmd_t                     cmd,
	output strmq_pkg::status_t                  status,
	input  wire [strmq_pkg::OP_W-1:0]           in_op,
	input  wire [strmq_pkg::VALUE_W-1:0]        in_value,
	input  wire [strmq_pkg::INDEX_W-1:0]        in_lo,
	input  wire [strmq_pkg::INDEX_W-1:0]        in_hi,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic [strmq_pkg::VALUE_W-1:0]       out_min,
	output logic                                out_empty,
	output logic                                out_bad
);

	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int LVL_W  = $clog2(LEVELS);
	localparam int KW     = ((LVL_W > strmq_pkg::LOG_W) ? LVL_W : strmq_pkg::LOG_W) + 1;
	localparam int QW     = (CNT_W > strmq_pkg::INDEX_W) ? CNT_W : strmq_pkg::INDEX_W;
	localparam int AW     = ((CNT_W > LEVELS) ? CNT_W : LEVELS) + 1;
	localparam int MW     = LVL_W + IDX_W;
	localparam int MEM_DEPTH = LEVELS * (2 ** IDX_W);
	localparam logic [KW-1:0]    LEVELS_K = KW'(LEVELS);
	localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);

	logic [strmq_pkg::OP_W-1:0]           op_q;
	logic signed [strmq_pkg::VALUE_W-1:0] value_q;
	logic [strmq_pkg::INDEX_W-1:0]        lo_q, hi_q;
	logic [CNT_W-1:0]                     count_q;
	logic [KW-1:0]                        k_q;
	logic signed [strmq_pkg::VALUE_W-1:0] cur_q, a_q;
	logic [IDX_W-1:0]                     rd_idx_q, second_q;
	logic                                 empty_q, bad_q;
	logic [strmq_pkg::VALUE_W-1:0]        rd_data_q;
	logic                                 out_valid_q;
	logic [strmq_pkg::VALUE_W-1:0]        out_min_q;
	logic                                 out_empty_q, out_bad_q;

	logic [strmq_pkg::VALUE_W-1:0]        mem_q [MEM_DEPTH];

	// append sweep
	logic [KW-1:0]    knext, lvl_prev;
	logic [AW-1:0]    idx_p1, size, start_full;
	logic [IDX_W-1:0] start_nx;
	logic             more, step;
	logic signed [strmq_pkg::VALUE_W-1:0] new_min, q_min;

	always_comb begin
		knext      = cmd.fill_step ? k_q + KW'(1) : KW'(1);
		lvl_prev   = knext - KW'(1);
		idx_p1     = AW'(count_q) + AW'(1);
		size       = AW'(1) << knext;
		start_full = idx_p1 - size;
		start_nx   = start_full[IDX_W-1:0];
		more       = (knext < LEVELS_K) && (idx_p1 >= size);
		step       = cmd.append_start || cmd.fill_step;
		new_min    = ($signed(rd_data_q) < cur_q) ? $signed(rd_data_q) : cur_q;
		q_min      = ($signed(rd_data_q) < a_q) ? $signed(rd_data_q) : a_q;
	end

	// query decode
	logic [QW-1:0]                 lo_ext, hi_ext, cnt_ext, sec_ext;
	logic [strmq_pkg::LEN_W-1:0]   len, pow, sec;
	logic [strmq_pkg::LOG_W-1:0]   q_k;
	logic [KW-1:0]                 q_k_ext;
	logic                          q_empty, q_bad;

	always_comb begin
		lo_ext  = QW'(lo_q);
		hi_ext  = QW'(hi_q);
		cnt_ext = QW'(count_q);
		len     = {1'b0, hi_q} - {1'b0, lo_q} + strmq_pkg::LEN_W'(1);
		q_k     = '0;
		for (int i = 0; i < strmq_pkg::LEN_W; i++) begin
			if (len[i]) q_k = strmq_pkg::LOG_W'(i);
		end
		q_k_ext = KW'(q_k);
		pow     = strmq_pkg::LEN_W'(1) << q_k;
		sec     = {1'b0, hi_q} + strmq_pkg::LEN_W'(1) - pow;
		sec_ext = QW'(sec);
		q_empty = lo_q > hi_q;
		q_bad   = (hi_ext >= cnt_ext) || (!q_empty && (q_k_ext >= LEVELS_K));
	end

	// memory ports
	logic          wr_en, rd_en;
	logic [MW-1:0] wr_addr, rd_addr;
	logic [strmq_pkg::VALUE_W-1:0] wr_data;

	always_comb begin
		wr_en   = cmd.append_start || cmd.fill_step;
		wr_addr = cmd.fill_step ? {k_q[LVL_W-1:0], rd_idx_q}
		                        : {LVL_W'(0), count_q[IDX_W-1:0]};
		wr_data = cmd.fill_step ? new_min : value_q;
		rd_en   = (step && more) || cmd.read_a || cmd.read_b;
		if (cmd.read_a) rd_addr = {k_q[LVL_W-1:0], lo_ext[IDX_W-1:0]};
		else if (cmd.read_b) rd_addr = {k_q[LVL_W-1:0], second_q};
		else rd_addr = {lvl_prev[LVL_W-1:0], start_nx};
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		if (rd_en) rd_data_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_count) count_q <= '0;
			else if (step && !more) count_q <= count_q + CNT_W'(1);
			if (cmd.result_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q    <= in_op;
			value_q <= in_value;
			lo_q    <= in_lo;
			hi_q    <= in_hi;
		end
		if (cmd.append_start) begin
			cur_q <= value_q;
			k_q   <= KW'(1);
		end else if (cmd.fill_step) begin
			cur_q <= new_min;
			k_q   <= knext;
		end else if (cmd.query_decode) begin
			k_q <= q_k_ext;
		end
		if (step && more) rd_idx_q <= start_nx;
		if (cmd.query_decode) begin
			empty_q  <= q_empty;
			bad_q    <= q_bad;
			second_q <= sec_ext[IDX_W-1:0];
		end
		if (cmd.read_b) a_q <= $signed(rd_data_q);
		if (cmd.result_load) begin
			out_min_q   <= (empty_q || bad_q) ? '0 : q_min;
			out_empty_q <= empty_q;
			out_bad_q   <= bad_q;
		end
	end

	always_comb begin
		status.op       = op_q;
		status.full     = count_q >= DEPTH_C;
		status.more     = more;
		status.flagged  = q_empty || q_bad;
		status.out_free = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_min   = out_min_q;
	assign out_empty = out_empty_q;
	assign out_bad   = out_bad_q;

endmodule

`default_nettype wire

>>> hw/rtl/sparse_table_range_minimum.sv
// Sparse-table range-minimum engine, top level.
// Depends on strmq_pkg, strmq_ctrl and strmq_dp.
//
// Input stream: one transfer per item. tuser carries the op (append, query,
// clear); tdata carries value, lo and hi. Append stores value at the next
// index and fills the power-of-two windows ending there; clear restarts
// loading. Only a query produces an output transfer: tdata is the minimum of
// values lo..hi, tuser flags an empty range (lo > hi) or a bad range (hi at or
// past the loaded count, or a window level of LEVELS or more); min is zero if flagged.
// An append fills one window level per cycle through the window memory, which has
// one read port and one write port. A flagged query skips the window reads. A
// query's result is on m_axis in the cycle s_axis_tready is high again.
// One item is worked on at a time; the next input is taken while a result
// still waits in the output register. If the receiver stalls, a query holds
// before its result until the output register frees; appends and clears go on.
// Reset empties the loaded array and drops any pending result; the window
// memory is not cleared, as entries are always written before they are read.
`default_nettype none

module sparse_table_range_minimum #(
	parameter int DEPTH  = strmq_pkg::DEPTH_DEF,
	parameter int LEVELS = strmq_pkg::LEVELS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire [strmq_pkg::S_DATA_W-1:0]    s_axis_tdata,  // value[31:0], lo[41:32], hi[51:42]
	input  wire [strmq_pkg::OP_W-1:0]        s_axis_tuser,  // op[1:0]
	output logic                             m_axis_tvalid,
	input  wire                              m_axis_tready,
	output logic [strmq_pkg::M_DATA_W-1:0]   m_axis_tdata,  // min_value[31:0]
	output logic [strmq_pkg::M_USER_W-1:0]   m_axis_tuser   // empty_range[0], bad_range[1]
);

	localparam int LO_LSB = strmq_pkg::VALUE_W;
	localparam int HI_LSB = strmq_pkg::VALUE_W + strmq_pkg::INDEX_W;

	strmq_pkg::cmd_t    cmd;
	strmq_pkg::status_t status;
	logic               out_empty, out_bad;

	strmq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	strmq_dp #(
		.DEPTH  (DEPTH),
		.LEVELS (LEVELS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_op     (s_axis_tuser),
		.in_value  (s_axis_tdata[strmq_pkg::VALUE_W-1:0]),
		.in_lo     (s_axis_tdata[LO_LSB +: strmq_pkg::INDEX_W]),
		.in_hi     (s_axis_tdata[HI_LSB +: strmq_pkg::INDEX_W]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_min   (m_axis_tdata),
		.out_empty (out_empty),
		.out_bad   (out_bad)
	);

	assign m_axis_tuser = {out_bad, out_empty};

endmodule

`default_nettype wire

>>> hw/rtl/strmq_checker.sv
// Port-level checks for the range-minimum engine, bound to its top level.
// Depends on strmq_pkg and sparse_table_range_minimum.
`default_nettype none

module strmq_checker (
	input wire                            clk,
	input wire                            arst_n,
	input wire                            s_axis_tvalid,
	input wire                            s_axis_tready,
	input wire                            m_axis_tvalid,
	input wire                            m_axis_tready,
	input wire [strmq_pkg::M_DATA_W-1:0]  m_axis_tdata,
	input wire [strmq_pkg::M_USER_W-1:0]  m_axis_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("output changed while stalled");

	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != '0) |-> m_axis_tdata == '0)
		else $error("flagged result with nonzero minimum");

	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready right after a transfer");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
		else $error("result appeared one cycle after an input transfer");

endmodule

bind sparse_table_range_minimum strmq_checker u_strmq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

>>> verif/tb_top.sv
// Testbench for sparse_table_range_minimum: appends, range queries and clears through
// the input stream; query results are checked against a behavioral range-minimum predictor.
// Depends on strmq_pkg and the sparse_table_range_minimum RTL.
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH  = strmq_pkg::DEPTH_DEF;
	localparam int TABLE_LEVELS = strmq_pkg::LEVELS_DEF;
	localparam int IDLE_LIMIT   = 2000;
	localparam int TAIL_CYCLES  = strmq_pkg::LEVELS_DEF + 20;
	localparam logic [strmq_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic signed [strmq_pkg::VALUE_W-1:0] min_value;
		logic                                 empty_range;
		logic                                 bad_range;
	} range_min_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           s_axis_tvalid;
	logic                           s_axis_tready;
	logic [strmq_pkg::S_DATA_W-1:0] s_axis_tdata;
	logic [strmq_pkg::OP_W-1:0]     s_axis_tuser;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready;
	logic [strmq_pkg::M_DATA_W-1:0] m_axis_tdata;
	logic [strmq_pkg::M_USER_W-1:0] m_axis_tuser;

	logic signed [strmq_pkg::VALUE_W-1:0] loaded_values [TABLE_DEPTH];
	int unsigned                          loaded_count;
	range_min_t                           expected_minima [$];
	int                                   mismatch_count;
	int                                   idle_cycles;
	bit                                   quiet;

	sparse_table_range_minimum dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always #2ns clk = ~clk;

	function automatic void predict_range_minimum(logic [strmq_pkg::OP_W-1:0] op,
			logic signed [strmq_pkg::VALUE_W-1:0] value,
			logic [strmq_pkg::INDEX_W-1:0] lo, logic [strmq_pkg::INDEX_W-1:0] hi);
		range_min_t                           r;
		logic signed [strmq_pkg::VALUE_W-1:0] m;
		int unsigned                          len;
		int unsigned                          lvl;
		case (op)
			strmq_pkg::OP_APPEND: begin
				if (loaded_count < TABLE_DEPTH) begin
					loaded_values[loaded_count] = value;
					loaded_count++;
				end
			end
			strmq_pkg::OP_CLEAR: loaded_count = 0;
			strmq_pkg::OP_QUERY: begin
				r = '0;
				r.empty_range = lo > hi;
				r.bad_range = hi >= loaded_count;
				if (!r.empty_range && !r.bad_range) begin
					len = hi - lo + 1;
					lvl = 0;
					while (len > 1) begin
						len >>= 1;
						lvl++;
					end
					if (lvl >= TABLE_LEVELS) begin
						r.bad_range = 1'b1;
					end else begin
						m = loaded_values[lo];
						for (int i = lo + 1; i <= hi; i++)
							if (loaded_values[i] < m)
								m = loaded_values[i];
						r.min_value = m;
					end
				end
				expected_minima = {expected_minima, r};
			end
			default: ;
		endcase
	endfunction

	// short idles mostly, now and then a long one
	function automatic int idle_length();
		return ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3) : $urandom_range(10, 60);
	endfunction

	function automatic logic [strmq_pkg::VALUE_W-1:0] random_value();
		int roll;
		roll = $urandom_range(0, 9);
		case (roll)
			0: begin
				case ($urandom_range(0, 3))
					0: return 32'h8000_0000;
					1: return 32'h7FFF_FFFF;
					2: return 32'h0000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			1: return $urandom_range(0, 16) - 8;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [strmq_pkg::INDEX_W-1:0] random_index(int unsigned low,
			int unsigned high);
		return strmq_pkg::INDEX_W'($urandom_range(low, high));
	endfunction

	function automatic void pick_range(output logic [strmq_pkg::INDEX_W-1:0] lo,
			output logic [strmq_pkg::INDEX_W-1:0] hi);
		int unsigned len;
		int          roll;
		roll = $urandom_range(0, 99);
		if (loaded_count == 0 || roll < 20) begin
			lo = random_index(0, 1023);
			hi = random_index(0, 1023);
		end else begin
			lo = random_index(0, loaded_count - 1);
			if (roll < 50) begin
				len = 1 << $urandom_range(0, TABLE_LEVELS - 1);
				hi = strmq_pkg::INDEX_W'((lo + len - 1 < loaded_count) ?
					lo + len - 1 : loaded_count - 1);
			end else if (roll < 75) begin
				hi = (lo + 7 < loaded_count) ?
					strmq_pkg::INDEX_W'(lo + $urandom_range(0, 7)) : lo;
			end else begin
				hi = random_index(lo, loaded_count - 1);
			end
		end
	endfunction

	task automatic send_item(logic [strmq_pkg::OP_W-1:0] op,
			logic [strmq_pkg::VALUE_W-1:0] value = '0,
			logic [strmq_pkg::INDEX_W-1:0] lo = '0, logic [strmq_pkg::INDEX_W-1:0] hi = '0);
		int gap;
		gap = (quiet || $urandom_range(0, 99) < 55) ? 0 : idle_length();
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {4'b0, hi, lo, value};
		do @(posedge clk); while (!s_axis_tready);
		predict_range_minimum(op, value, lo, hi);
	endtask

	task automatic send_query(int unsigned lo, int unsigned hi);
		send_item(strmq_pkg::OP_QUERY, '0, strmq_pkg::INDEX_W'(lo), strmq_pkg::INDEX_W'(hi));
	endtask

	task automatic drain_results(int tail);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		wait (expected_minima.size() == 0);
		repeat (tail) @(posedge clk);
	endtask

	task automatic test_empty_table();
		send_query(0, 0);
		send_query(5, 2);
		send_item(OP_UNUSED, 32'hFFFF_FFFF, 10'h3FF, 10'h3FF);
		send_query(0, 0);
	endtask

	task automatic test_directed_extremes();
		send_item(strmq_pkg::OP_APPEND, 32'h7FFF_FFFF);
		send_item(strmq_pkg::OP_APPEND, 32'h8000_0000);
		send_item(strmq_pkg::OP_APPEND, 32'h0000_0000);
		send_item(strmq_pkg::OP_APPEND, 32'hFFFF_FFFF);
		send_item(strmq_pkg::OP_APPEND, 32'h0000_0001);
		send_item(strmq_pkg::OP_APPEND, 32'h5555_5555);
		send_item(strmq_pkg::OP_APPEND, 32'hAAAA_AAAA);
		send_query(0, 0);
		send_query(1, 1);
		send_query(0, 6);
		send_query(2, 3);
		send_query(3, 6);
		send_query(0, 7);
		send_query(4, 2);
		send_query(6, 1023);
		send_query(1023, 0);
		send_query(1023, 1023);
		send_item(OP_UNUSED, 32'h1234_5678, 10'h155, 10'h2AA);
		send_query(0, 6);
		send_item(strmq_pkg::OP_CLEAR);
		send_query(0, 0);
	endtask

	task automatic test_full_table();
		logic [strmq_pkg::INDEX_W-1:0] lo;
		logic [strmq_pkg::INDEX_W-1:0] hi;
		quiet = 1'b0;
		send_item(strmq_pkg::OP_CLEAR);
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			quiet = ((i / 128) % 3 == 2);
			send_item(strmq_pkg::OP_APPEND, random_value());
		end
		quiet = 1'b0;
		// table is full: these must be dropped
		send_item(strmq_pkg::OP_APPEND, 32'h8000_0000);
		send_item(strmq_pkg::OP_APPEND, 32'h8000_0000);
		send_query(0, 1023);
		send_query(1023, 1023);
		send_query(0, 511);
		send_query(512, 1023);
		send_query(1, 1022);
		drain_results(0);
		for (int i = 0; i < 50; i++) begin
			pick_range(lo, hi);
			send_query(lo, hi);
		end
	endtask

	task automatic test_random_mix();
		logic [strmq_pkg::INDEX_W-1:0] lo;
		logic [strmq_pkg::INDEX_W-1:0] hi;
		int                            roll;
		for (int i = 0; i < 80; i++) begin
			quiet = (i % 40 >= 20 && i % 40 < 32);
			if (i == 40)
				drain_results(0);
			roll = $urandom_range(0, 99);
			if (roll < 4) begin
				send_item(strmq_pkg::OP_CLEAR, random_value(), random_index(0, 1023),
					random_index(0, 1023));
			end else if (roll < 8) begin
				send_item(OP_UNUSED, random_value(), random_index(0, 1023),
					random_index(0, 1023));
			end else if (roll < 50) begin
				send_item(strmq_pkg::OP_APPEND, random_value(), random_index(0, 1023),
					random_index(0, 1023));
			end else begin
				pick_range(lo, hi);
				send_item(strmq_pkg::OP_QUERY, random_value(), lo, hi);
			end
		end
		quiet = 1'b0;
	endtask

	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (quiet || $urandom_range(0, 99) < 65) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b0;
				repeat (idle_length()) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		range_min_t want;
		range_min_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.min_value   = m_axis_tdata;
			got.empty_range = m_axis_tuser[0];
			got.bad_range   = m_axis_tuser[1];
			if (expected_minima.size() == 0) begin
				$display("%0t: unexpected result: min_value %0d empty_range %0b bad_range %0b",
					$time, got.min_value, got.empty_range, got.bad_range);
				mismatch_count++;
			end else begin
				want = expected_minima.pop_front();
				if (got.min_value !== want.min_value) begin
					$display("%0t: min_value expected %0d actual %0d",
						$time, want.min_value, got.min_value);
					mismatch_count++;
				end
				if (got.empty_range !== want.empty_range) begin
					$display("%0t: empty_range expected %0b actual %0b",
						$time, want.empty_range, got.empty_range);
					mismatch_count++;
				end
				if (got.bad_range !== want.bad_range) begin
					$display("%0t: bad_range expected %0b actual %0b",
						$time, want.bad_range, got.bad_range);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		s_axis_tuser   = '0;
		quiet          = 1'b0;
		mismatch_count = 0;
		idle_cycles    = 0;
		loaded_count   = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_empty_table();
		test_directed_extremes();
		test_full_table();
		test_random_mix();
		drain_results(TAIL_CYCLES);
		if (mismatch_count == 0 && expected_minima.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire
